// ===== sv/tcw_pkg.sv =====
// tcw_pkg: shared types and constants of the text console writer.
// No dependencies; used by the control unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   localparam int CHAR_W     = 8;
   localparam int CELL_W     = 2 * CHAR_W;
   localparam int POS_W      = 11;
   localparam int CSR_IDX_W  = 8;

   localparam logic [CHAR_W-1:0] LINE_FEED       = 8'd10;
   localparam logic [CHAR_W-1:0] CARRIAGE_RETURN = 8'd13;

   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_ENABLE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_COLOR = 8'd1;

   localparam logic             SCROLL_ENABLE_RESET = 1'b1;
   localparam logic [CHAR_W-1:0] DEFAULT_COLOR_RESET = 8'd15;

   typedef enum logic [1:0] {
      CMD_PUT        = 2'd0,
      CMD_SET_CURSOR = 2'd1,
      CMD_CLEAR      = 2'd2,
      CMD_READ       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SETCUR,
      ST_CLEAR,
      ST_SCROLL,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic              scroll_enable;
      logic [CHAR_W-1:0] default_color;
   } cfg_type;

endpackage

`default_nettype wire

// ===== sv/tcw_cell_ram.sv =====
// tcw_cell_ram: cell store, one write port and one registered read port.
// Depends on nothing; instantiated by the top level.
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 16
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
// tcw_ctrl: command sequencer, cursor tracking and result registers.
// Depends on tcw_pkg; drives the cell store ports of tcw_cell_ram.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int CELLS   = COLUMNS * ROWS,
   parameter int AW      = $clog2(CELLS + 1),
   parameter int RAW     = $clog2(CELLS)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [1:0]                  cmd,
   input  wire logic [tcw_pkg::CHAR_W-1:0]  chr,
   input  wire logic [tcw_pkg::CHAR_W-1:0]  color,
   input  wire logic [tcw_pkg::POS_W-1:0]   position,
   input  wire tcw_pkg::cfg_type            cfg,
   output logic                             ram_we,
   output logic [RAW-1:0]                   ram_waddr,
   output logic [tcw_pkg::CELL_W-1:0]       ram_wdata,
   output logic [RAW-1:0]                   ram_raddr,
   input  wire logic [tcw_pkg::CELL_W-1:0]  ram_rdata,
   output logic                             rsp_valid,
   output logic [tcw_pkg::POS_W-1:0]        rsp_cursor,
   output logic [tcw_pkg::CHAR_W-1:0]       rsp_read_char,
   output logic [tcw_pkg::CHAR_W-1:0]       rsp_read_color,
   output logic                             rsp_dropped
);

   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int XW = (AW > tcw_pkg::POS_W) ? AW : tcw_pkg::POS_W;
   localparam logic [AW-1:0]  CELLS_A     = AW'(CELLS);
   localparam logic [AW-1:0]  COLUMNS_A   = AW'(COLUMNS);
   localparam logic [AW-1:0]  LAST_BASE_A = AW'((ROWS - 1) * COLUMNS);
   localparam logic [XW-1:0]  CELLS_X     = XW'(CELLS);
   localparam logic [RW-1:0]  LAST_ROW    = RW'(ROWS - 1);
   localparam logic [RAW-1:0] COLUMNS_R   = RAW'(COLUMNS);
   localparam logic [RAW-1:0] LAST_CELL_R = RAW'(CELLS - 1);

   tcw_pkg::state_type state_ff, state_in;
   logic [AW-1:0]  cursor_ff, cursor_in;
   logic [AW-1:0]  base_ff, base_in;     // start of the cursor's row
   logic [RW-1:0]  row_ff, row_in;       // clamped to the last row
   logic [AW-1:0]  target_ff, target_in;
   logic [RAW-1:0] idx_ff, idx_in;
   logic [tcw_pkg::CHAR_W-1:0] fill_ff, fill_in;
   logic           wr_pend_ff, wr_pend_in;
   logic [RAW-1:0] wr_addr_ff, wr_addr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::CHAR_W-1:0] rd_char_ff, rd_char_in;
   logic [tcw_pkg::CHAR_W-1:0] rd_color_ff, rd_color_in;
   logic           dropped_ff, dropped_in;

   tcw_pkg::cmd_type cmd_t;
   logic            accept;
   logic [XW-1:0]   pos_x;
   logic [XW-1:0]   clamp_x;
   logic            pos_in_range;
   logic [AW-1:0]   base_next;
   logic [AW-1:0]   cursor_inc;
   logic            on_last_row;
   logic            at_end;
   logic [XW-1:0]   cursor_x;

   assign cmd_t        = tcw_pkg::cmd_type'(cmd);
   assign accept       = start && (state_ff == tcw_pkg::ST_IDLE);
   assign pos_x        = XW'(position);
   assign pos_in_range = pos_x < CELLS_X;
   assign clamp_x      = pos_in_range ? pos_x : CELLS_X;
   assign base_next    = base_ff + COLUMNS_A;
   assign cursor_inc   = cursor_ff + AW'(1);
   assign on_last_row  = row_ff == LAST_ROW;
   assign at_end       = cursor_ff == CELLS_A;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (cmd_t)
                  tcw_pkg::CMD_PUT: begin
                     if (chr == tcw_pkg::LINE_FEED && on_last_row && cfg.scroll_enable) begin
                        state_in = tcw_pkg::ST_SCROLL;
                     end
                  end
                  tcw_pkg::CMD_SET_CURSOR: state_in = tcw_pkg::ST_SETCUR;
                  tcw_pkg::CMD_CLEAR:      state_in = tcw_pkg::ST_CLEAR;
                  tcw_pkg::CMD_READ: begin
                     if (pos_in_range) begin
                        state_in = tcw_pkg::ST_READ;
                     end
                  end
               endcase
            end
         end
         tcw_pkg::ST_READ: state_in = tcw_pkg::ST_IDLE;
         tcw_pkg::ST_SETCUR: begin
            if (!(target_ff >= base_next && !on_last_row)) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_CLEAR: begin
            if (idx_ff == LAST_CELL_R) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_SCROLL: begin
            if (idx_ff == LAST_CELL_R) begin
               state_in = tcw_pkg::ST_DRAIN;
            end
         end
         tcw_pkg::ST_DRAIN: state_in = tcw_pkg::ST_IDLE;
         default: state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cursor_in    = cursor_ff;
      base_in      = base_ff;
      row_in       = row_ff;
      target_in    = target_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      rsp_valid_in = 1'b0;
      rd_char_in   = '0;
      rd_color_in  = '0;
      dropped_in   = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = cursor_ff[RAW-1:0];
      ram_wdata    = {color, chr};
      ram_raddr    = clamp_x[RAW-1:0];

      // delayed write of a scroll copy
      if (wr_pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = wr_addr_ff;
         ram_wdata = {cfg.default_color, ram_rdata[tcw_pkg::CHAR_W-1:0]};
      end

      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (cmd_t)
                  tcw_pkg::CMD_PUT: begin
                     if (chr == tcw_pkg::LINE_FEED) begin
                        if (on_last_row) begin
                           cursor_in = LAST_BASE_A;
                           base_in   = LAST_BASE_A;
                           if (cfg.scroll_enable) begin
                              idx_in = COLUMNS_R;
                           end else begin
                              rsp_valid_in = 1'b1;
                           end
                        end else begin
                           cursor_in    = base_next;
                           base_in      = base_next;
                           row_in       = row_ff + RW'(1);
                           rsp_valid_in = 1'b1;
                        end
                     end else if (chr == tcw_pkg::CARRIAGE_RETURN) begin
                        cursor_in    = base_ff;
                        rsp_valid_in = 1'b1;
                     end else if (at_end) begin
                        dropped_in   = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        ram_we       = 1'b1;
                        ram_waddr    = cursor_ff[RAW-1:0];
                        ram_wdata    = {color, chr};
                        cursor_in    = cursor_inc;
                        rsp_valid_in = 1'b1;
                        // wrap onto the next row; the last row runs past the end
                        if (cursor_inc == base_next && !on_last_row) begin
                           base_in = base_next;
                           row_in  = row_ff + RW'(1);
                        end
                     end
                  end
                  tcw_pkg::CMD_SET_CURSOR: begin
                     cursor_in = clamp_x[AW-1:0];
                     target_in = clamp_x[AW-1:0];
                     base_in   = '0;
                     row_in    = '0;
                  end
                  tcw_pkg::CMD_CLEAR: begin
                     fill_in   = color;
                     idx_in    = '0;
                     cursor_in = '0;
                     base_in   = '0;
                     row_in    = '0;
                  end
                  tcw_pkg::CMD_READ: begin
                     if (!pos_in_range) begin
                        rsp_valid_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         tcw_pkg::ST_READ: begin
            rd_char_in   = ram_rdata[tcw_pkg::CHAR_W-1:0];
            rd_color_in  = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            rsp_valid_in = 1'b1;
         end
         tcw_pkg::ST_SETCUR: begin
            // one row per cycle until the row holding the target is found
            if (target_ff >= base_next && !on_last_row) begin
               base_in = base_next;
               row_in  = row_ff + RW'(1);
            end else begin
               rsp_valid_in = 1'b1;
            end
         end
         tcw_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = {fill_ff, {tcw_pkg::CHAR_W{1'b0}}};
            if (idx_ff == LAST_CELL_R) begin
               rsp_valid_in = 1'b1;
            end else begin
               idx_in = idx_ff + RAW'(1);
            end
         end
         tcw_pkg::ST_SCROLL: begin
            // ascending source order: a cell is read before it is overwritten
            ram_raddr  = idx_ff;
            wr_pend_in = 1'b1;
            wr_addr_in = idx_ff - COLUMNS_R;
            if (idx_ff != LAST_CELL_R) begin
               idx_in = idx_ff + RAW'(1);
            end
         end
         tcw_pkg::ST_DRAIN: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_IDLE;
         cursor_ff    <= '0;
         base_ff      <= '0;
         row_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         base_ff      <= base_in;
         row_ff       <= row_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      idx_ff      <= idx_in;
      fill_ff     <= fill_in;
      wr_addr_ff  <= wr_addr_in;
      rd_char_ff  <= rd_char_in;
      rd_color_ff <= rd_color_in;
      dropped_ff  <= dropped_in;
   end

   assign cursor_x       = XW'(cursor_ff);
   assign busy           = state_ff != tcw_pkg::ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor     = cursor_x[tcw_pkg::POS_W-1:0];
   assign rsp_read_char  = rd_char_ff;
   assign rsp_read_color = rd_color_ff;
   assign rsp_dropped    = dropped_ff;

endmodule

`default_nettype wire

// ===== sv/text_console_writer_top.sv =====
// text_console_writer_top: text console, configuration registers and wiring.
// Depends on tcw_pkg, tcw_cell_ram and tcw_ctrl.
//
// Usage: a command is transferred on the clock edge where start is high and
// busy is low; req_cmd selects put character, set cursor, clear or read cell.
// Each command gives one result, shown for one cycle with rsp_valid high; the
// receiver cannot stall, so it must take every result as it appears.
// The result strobe is registered. A command that keeps busy high raises it as
// busy falls; put character, carriage return, line feed without scroll and a
// read past the last cell raise it in the cycle after the transfer.
// Busy is high for read cell during the registered cell store read, for set
// cursor during the row search (one row a cycle), for clear screen while one
// cell is written a cycle, and for line feed with scroll while one cell is
// copied a cycle through the read and write ports.
// A new command may be transferred while the previous result is on the ports.
// Configuration writes on the csr_ channel are always ready and take effect at
// once; the user makes them only while the block is idle; no check enforces it.
// Reset puts the cursor at 0, scroll_enable at 1 and default_color at 15;
// the cell store is undefined until a clear command.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_top #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [1:0]                     req_cmd,
   input  wire logic [tcw_pkg::CHAR_W-1:0]     req_chr,
   input  wire logic [tcw_pkg::CHAR_W-1:0]     req_color,
   input  wire logic [tcw_pkg::POS_W-1:0]      req_position,
   output logic                                rsp_valid,
   output logic [tcw_pkg::POS_W-1:0]           rsp_cursor,
   output logic [tcw_pkg::CHAR_W-1:0]          rsp_read_char,
   output logic [tcw_pkg::CHAR_W-1:0]          rsp_read_color,
   output logic                                rsp_dropped,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tcw_pkg::CHAR_W-1:0]     csr_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS + 1);
   localparam int RAW   = $clog2(CELLS);

   tcw_pkg::cfg_type cfg_ff, cfg_in;

   logic                        ram_we;
   logic [RAW-1:0]              ram_waddr;
   logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
   logic [RAW-1:0]              ram_raddr;
   logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tcw_pkg::CSR_SCROLL_ENABLE: cfg_in.scroll_enable = csr_data[0];
            tcw_pkg::CSR_DEFAULT_COLOR: cfg_in.default_color = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scroll_enable <= tcw_pkg::SCROLL_ENABLE_RESET;
         cfg_ff.default_color <= tcw_pkg::DEFAULT_COLOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcw_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .CELLS   (CELLS),
      .AW      (AW),
      .RAW     (RAW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .cmd            (req_cmd),
      .chr            (req_chr),
      .color          (req_color),
      .position       (req_position),
      .cfg            (cfg_ff),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata),
      .rsp_valid      (rsp_valid),
      .rsp_cursor     (rsp_cursor),
      .rsp_read_char  (rsp_read_char),
      .rsp_read_color (rsp_read_color),
      .rsp_dropped    (rsp_dropped)
   );

   tcw_cell_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (RAW),
      .DATA_W (tcw_pkg::CELL_W)
   ) u_cell_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for text_console_writer_top.
// Depends on tcw_pkg and the RTL; keeps its own screen model and compares
// every result strobe against it.
`timescale 1ns / 1ps

module tb_top;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int PHASE_ITEMS = 115;

   typedef struct packed {
      tcw_pkg::cmd_type           cmd;
      logic [tcw_pkg::CHAR_W-1:0] chr;
      logic [tcw_pkg::CHAR_W-1:0] color;
      logic [tcw_pkg::POS_W-1:0]  position;
   } console_cmd_type;

   typedef struct packed {
      logic [tcw_pkg::POS_W-1:0]  cursor;
      logic [tcw_pkg::CHAR_W-1:0] read_char;
      logic [tcw_pkg::CHAR_W-1:0] read_color;
      logic                       dropped;
   } console_rsp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [1:0]                    req_cmd = '0;
   logic [tcw_pkg::CHAR_W-1:0]    req_chr = '0;
   logic [tcw_pkg::CHAR_W-1:0]    req_color = '0;
   logic [tcw_pkg::POS_W-1:0]     req_position = '0;
   logic                          rsp_valid;
   logic [tcw_pkg::POS_W-1:0]     rsp_cursor;
   logic [tcw_pkg::CHAR_W-1:0]    rsp_read_char;
   logic [tcw_pkg::CHAR_W-1:0]    rsp_read_color;
   logic                          rsp_dropped;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [tcw_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tcw_pkg::CHAR_W-1:0]    csr_data = '0;

   // screen model
   logic [tcw_pkg::CELL_W-1:0]    screen_mem [CELLS];
   int unsigned                   model_cursor = 0;
   logic                          model_scroll_en = tcw_pkg::SCROLL_ENABLE_RESET;
   logic [tcw_pkg::CHAR_W-1:0]    model_default_color = tcw_pkg::DEFAULT_COLOR_RESET;

   console_cmd_type      pending_cmds [$];
   console_rsp_type      expected_rsps [$];
   int unsigned          mismatch_count = 0;
   int unsigned          cycle_count = 0;
   int unsigned          burst_left = 8;
   int unsigned          gap_left = 0;

   text_console_writer_top #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_chr        (req_chr),
      .req_color      (req_color),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_cursor     (rsp_cursor),
      .rsp_read_char  (rsp_read_char),
      .rsp_read_color (rsp_read_color),
      .rsp_dropped    (rsp_dropped),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #1 clock = ~clock;

   task automatic console_step(input console_cmd_type c, output console_rsp_type r);
      int unsigned row;
      r = '0;
      row = model_cursor / COLUMNS;
      if (row >= ROWS) row = ROWS - 1;   // past the end counts as last row
      case (c.cmd)
         tcw_pkg::CMD_PUT: begin
            if (c.chr == tcw_pkg::LINE_FEED) begin
               if (row == ROWS - 1) begin
                  if (model_scroll_en) begin
                     for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen_mem[i] = {model_default_color, screen_mem[i + COLUMNS][7:0]};
                  end
                  model_cursor = (ROWS - 1) * COLUMNS;
               end else begin
                  model_cursor = (row + 1) * COLUMNS;
               end
            end else if (c.chr == tcw_pkg::CARRIAGE_RETURN) begin
               model_cursor = row * COLUMNS;
            end else if (model_cursor >= CELLS) begin
               r.dropped = 1'b1;
            end else begin
               screen_mem[model_cursor] = {c.color, c.chr};
               model_cursor++;
            end
         end
         tcw_pkg::CMD_SET_CURSOR: begin
            model_cursor = (c.position >= CELLS) ? CELLS : c.position;
         end
         tcw_pkg::CMD_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               screen_mem[i] = {c.color, 8'h00};
            model_cursor = 0;
         end
         default: begin
            if (c.position < CELLS) begin
               r.read_char  = screen_mem[c.position][7:0];
               r.read_color = screen_mem[c.position][15:8];
            end
         end
      endcase
      r.cursor = model_cursor[tcw_pkg::POS_W-1:0];
   endtask

   task automatic push_cmd(input tcw_pkg::cmd_type cmd, input int unsigned chr,
                           input int unsigned color, input int unsigned pos);
      console_cmd_type c;
      c.cmd      = cmd;
      c.chr      = chr[tcw_pkg::CHAR_W-1:0];
      c.color    = color[tcw_pkg::CHAR_W-1:0];
      c.position = pos[tcw_pkg::POS_W-1:0];
      pending_cmds.push_back(c);
   endtask

   task automatic push_put(input int unsigned chr, input int unsigned color);
      push_cmd(tcw_pkg::CMD_PUT, chr, color, $urandom_range(0, 2047));
   endtask

   task automatic push_cursor(input int unsigned pos);
      push_cmd(tcw_pkg::CMD_SET_CURSOR, $urandom_range(0, 255), $urandom_range(0, 255), pos);
   endtask

   task automatic push_read(input int unsigned pos);
      push_cmd(tcw_pkg::CMD_READ, $urandom_range(0, 255), $urandom_range(0, 255), pos);
   endtask

   task automatic push_text(input int unsigned len);
      for (int i = 0; i < len; i++)
         push_put($urandom_range(0, 255), $urandom_range(0, 255));
   endtask

   task automatic report_mismatch(input string what, input int unsigned exp_v,
                                  input int unsigned act_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
   endtask

   // sampled away from the rising edge so the driver and monitor have settled
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || expected_rsps.size() != 0 || start || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [tcw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tcw_pkg::CHAR_W-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic en, input logic [tcw_pkg::CHAR_W-1:0] dflt);
      csr_write(tcw_pkg::CSR_SCROLL_ENABLE, {7'($urandom_range(0, 127)), en});
      csr_write(tcw_pkg::CSR_DEFAULT_COLOR, dflt);
   endtask

   // mostly text lines and cursor moves; a little raw noise
   task automatic fill_random(input int unsigned n);
      int unsigned target;
      int unsigned kind;
      int unsigned term;
      target = pending_cmds.size() + n;
      while (pending_cmds.size() < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            push_text($urandom_range(0, 30));
            term = $urandom_range(0, 99);
            if (term < 60) push_put(tcw_pkg::LINE_FEED, $urandom_range(0, 255));
            else if (term < 85) push_put(tcw_pkg::CARRIAGE_RETURN, $urandom_range(0, 255));
         end else if (kind < 60) begin
            push_cursor((ROWS - 1) * COLUMNS + $urandom_range(0, COLUMNS - 1));
            push_text($urandom_range(0, 4));
            push_put(tcw_pkg::LINE_FEED, $urandom_range(0, 255));
            push_read($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
         end else if (kind < 70) begin
            push_cursor($urandom_range(0, 2047));
         end else if (kind < 85) begin
            push_read(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                                  : $urandom_range(0, CELLS - 1));
         end else if (kind < 93) begin
            push_cursor($urandom_range(CELLS - 10, CELLS - 1));
            push_text($urandom_range(5, 15));
            if ($urandom_range(0, 1))
               push_put(tcw_pkg::CARRIAGE_RETURN, $urandom_range(0, 255));
         end else if (kind < 96) begin
            push_cmd(tcw_pkg::CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 2047));
         end else begin
            push_cmd(tcw_pkg::cmd_type'($urandom_range(0, 3)), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 2047));
         end
      end
   endtask

   // driver: bursts of commands with random gaps
   always @(posedge clock) begin : driver
      console_cmd_type cur;
      console_cmd_type nxt;
      console_rsp_type rsp;
      if (!reset) begin
         if (start && !busy) begin
            cur.cmd      = tcw_pkg::cmd_type'(req_cmd);
            cur.chr      = req_chr;
            cur.color    = req_color;
            cur.position = req_position;
            console_step(cur, rsp);
            expected_rsps.push_back(rsp);
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         if (start && busy) begin
            // hold the command until the transfer
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            nxt = pending_cmds.pop_front();
            req_cmd      <= nxt.cmd;
            req_chr      <= nxt.chr;
            req_color    <= nxt.color;
            req_position <= nxt.position;
            start        <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : csr_tracker
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == tcw_pkg::CSR_SCROLL_ENABLE) model_scroll_en = csr_data[0];
         else if (csr_index == tcw_pkg::CSR_DEFAULT_COLOR) model_default_color = csr_data;
      end
   end

   always @(posedge clock) begin : monitor
      console_rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("result with nothing pending, cursor", 0, rsp_cursor);
         end else begin
            exp_r = expected_rsps.pop_front();
            if (rsp_cursor !== exp_r.cursor)
               report_mismatch("cursor", exp_r.cursor, rsp_cursor);
            if (rsp_read_char !== exp_r.read_char)
               report_mismatch("read_char", exp_r.read_char, rsp_read_char);
            if (rsp_read_color !== exp_r.read_color)
               report_mismatch("read_color", exp_r.read_color, rsp_read_color);
            if (rsp_dropped !== exp_r.dropped)
               report_mismatch("dropped", exp_r.dropped, rsp_dropped);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: store is undefined until the first clear
      push_cmd(tcw_pkg::CMD_CLEAR, 8'h55, 8'h07, 0);
      push_read(0);
      push_put(8'h00, 8'h00);              // byte zero is printable
      push_put(8'hFF, 8'hFF);
      push_read(0);
      push_read(1);
      push_put(tcw_pkg::CARRIAGE_RETURN, 8'h12);
      push_put(8'h41, 8'h1E);
      push_put(tcw_pkg::LINE_FEED, 8'h00);
      push_cursor(CELLS - 1);
      push_put(8'h5A, 8'hAA);              // last cell, cursor goes past end
      push_put(8'h78, 8'h33);              // dropped
      push_read(CELLS - 1);
      push_read(CELLS);
      push_read(2047);
      push_put(tcw_pkg::CARRIAGE_RETURN, 8'h00);    // return from past the end
      push_cursor(2047);                   // clamps to past the end
      push_put(tcw_pkg::LINE_FEED, 8'h00);          // scrolls
      push_read(CELLS - COLUMNS - 1);
      push_read(CELLS - 1);
      push_cursor(0);
      push_put(tcw_pkg::LINE_FEED, 8'hFF);
      push_cursor(COLUMNS - 1);
      push_put(8'h7E, 8'hC3);
      push_cursor(1024);
      wait_idle();

      set_config(1'b0, 8'h00);
      push_cursor(CELLS - 50);
      push_put(tcw_pkg::LINE_FEED, 8'h00);          // last row, no scroll
      push_read(CELLS - COLUMNS - 1);
      fill_random(PHASE_ITEMS);
      wait_idle();

      set_config(1'b1, 8'hFF);
      fill_random(PHASE_ITEMS);
      wait_idle();

      set_config(1'b1, 8'($urandom_range(0, 255)));
      fill_random(PHASE_ITEMS);
      wait_idle();

      set_config(1'b0, 8'hFF);
      fill_random(PHASE_ITEMS);
      wait_idle();

      set_config(1'b1, 8'h00);
      fill_random(PHASE_ITEMS);
      wait_idle();

      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
